@@ hw/rtl/lpht_pkg.sv @@
package lpht_pkg;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_e;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_key_en;
    tag_e wr_tag;
  } mem_cmd_t;

endpackage

@@ hw/rtl/lpht_mod.sv @@
module lpht_mod #(
  parameter int unsigned N_W   = 7,
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  input  logic [N_W-1:0]           n_i,
  output logic                     done_o,
  output logic [IDX_W-1:0]         rem_o
);
  import lpht_pkg::*;

  localparam int unsigned DVD_W = KEY_W + 1;
  localparam int unsigned BITS  = 2;
  localparam int unsigned STEPS = DVD_W / BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q;

  // two restoring remainder steps per cycle
  always_comb begin
    logic [N_W:0] t;
    rem_d = rem_q;
    for (int j = 0; j < BITS; j++) begin
      t = {rem_d, dvd_q[DVD_W-1-j]};
      if (t >= {1'b0, n_i}) begin
        rem_d = N_W'(t - {1'b0, n_i});
      end else begin
        rem_d = N_W'(t);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= {1'b0, key_i};
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << BITS;
    end
  end

  assign done_o = done_q;
  assign rem_o  = IDX_W'(rem_q);

endmodule

@@ hw/rtl/lpht_store.sv @@
module lpht_store #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpht_pkg::mem_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic [lpht_pkg::KEY_W-1:0] wr_key_i,
  output lpht_pkg::tag_e             rd_tag_o,
  output logic [lpht_pkg::KEY_W-1:0] rd_key_o,
  output logic                       ready_o
);
  import lpht_pkg::*;

  tag_e             tag_mem [MAX_SLOTS];
  logic [KEY_W-1:0] key_mem [MAX_SLOTS];
  tag_e             rd_tag_q;
  logic [KEY_W-1:0] rd_key_q;
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_addr_q;

  // tag clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IDX_W'(MAX_SLOTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tag_mem[clr_addr_q] <= TAG_EMPTY;
    end else if (cmd_i.wr_en) begin
      tag_mem[wr_addr_i] <= cmd_i.wr_tag;
    end
    if (cmd_i.rd_en) begin
      rd_tag_q <= tag_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key_en) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr_i];
    end
  end

  assign rd_tag_o = rd_tag_q;
  assign rd_key_o = rd_key_q;
  assign ready_o  = !clr_busy_q;

endmodule

@@ hw/rtl/linear_probe_hash_table_core.sv @@
// a request first finds its home slot, then probes k slots, k = 1..slot count; an unused op skips both
// the home slot comes from a 2-bit-per-cycle remainder unit, then the probe reads one slot per cycle
// one request is in flight at a time
// reset: slot count returns to 64 and all slot tags are swept to empty, with in_ready_o
// low until the sweep ends; stored keys are not cleared
module linear_probe_hash_table_core #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lpht_pkg::OP_W-1:0]   op_i,
  input  logic [lpht_pkg::KEY_W-1:0]  key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lpht_pkg::STAT_W-1:0] status_o,
  output logic [lpht_pkg::SLOT_W-1:0] slot_o
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned N_W   = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] slot_count_q;
  logic [N_W-1:0]   n_cnt;
  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0] chk_ptr_q, chk_ptr_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [N_W-1:0]   chk_cnt_q, chk_cnt_d;
  status_e          res_status_q, res_status_d;
  logic [IDX_W-1:0] res_slot_q, res_slot_d;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic             in_xfer;
  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;
  mem_cmd_t         mem_cmd;
  logic [IDX_W-1:0] mem_rd_addr;
  tag_e             mem_rd_tag;
  logic [KEY_W-1:0] mem_rd_key;
  logic             mem_ready;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p,
                                                 input logic [N_W-1:0] n);
    logic [N_W-1:0] p1;
    p1 = N_W'(p) + 1'b1;
    if (p1 == n) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    if (slot_count_q == '0) begin
      n_cnt = N_W'(1);
    end else if (32'(slot_count_q) > MAX_SLOTS) begin
      n_cnt = N_W'(MAX_SLOTS);
    end else begin
      n_cnt = N_W'(slot_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && mem_ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  // the write at the end of a request never meets a read of the next one:
  // every request spends the remainder cycles before its first read
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    chk_ptr_d    = chk_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    chk_cnt_d    = chk_cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    mod_start    = 1'b0;
    mem_cmd      = '{rd_en: 1'b0, wr_en: 1'b0, wr_key_en: 1'b0, wr_tag: TAG_USED};
    mem_rd_addr  = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = op_i;
          key_d = key_i;
          if (op_i == OP_INSERT || op_i == OP_SEARCH || op_i == OP_DELETE) begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end else begin
            res_status_d = ST_NOT_FOUND;
            res_slot_d   = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          mem_cmd.rd_en = 1'b1;
          mem_rd_addr   = mod_rem;
          chk_ptr_d     = mod_rem;
          rd_ptr_d      = next_slot(mod_rem, n_cnt);
          chk_cnt_d     = '0;
          state_d       = S_PROBE;
        end
      end
      S_PROBE: begin
        if (op_q == OP_INSERT && mem_rd_tag != TAG_USED) begin
          mem_cmd.wr_en     = 1'b1;
          mem_cmd.wr_key_en = 1'b1;
          mem_cmd.wr_tag    = TAG_USED;
          res_status_d      = ST_OK;
          res_slot_d        = chk_ptr_q;
          state_d           = S_DONE;
        end else if (op_q != OP_INSERT && mem_rd_tag == TAG_EMPTY) begin
          res_status_d = ST_NOT_FOUND;
          res_slot_d   = '0;
          state_d      = S_DONE;
        end else if (op_q != OP_INSERT && mem_rd_tag == TAG_USED && mem_rd_key == key_q) begin
          mem_cmd.wr_en  = (op_q == OP_DELETE);
          mem_cmd.wr_tag = TAG_DELETED;
          res_status_d   = ST_OK;
          res_slot_d     = chk_ptr_q;
          state_d        = S_DONE;
        end else if (chk_cnt_q + 1'b1 == n_cnt) begin
          res_status_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          res_slot_d   = '0;
          state_d      = S_DONE;
        end else begin
          mem_cmd.rd_en = 1'b1;
          chk_ptr_d     = rd_ptr_q;
          rd_ptr_d      = next_slot(rd_ptr_q, n_cnt);
          chk_cnt_d     = chk_cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = SLOT_W'(res_slot_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    chk_ptr_q    <= chk_ptr_d;
    rd_ptr_q     <= rd_ptr_d;
    chk_cnt_q    <= chk_cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  lpht_mod #(
    .N_W   (N_W),
    .IDX_W (IDX_W)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .n_i     (n_cnt),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  lpht_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (chk_ptr_q),
    .wr_key_i  (key_q),
    .rd_tag_o  (mem_rd_tag),
    .rd_key_o  (mem_rd_key),
    .ready_o   (mem_ready)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;

`ifndef SYNTHESIS
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> chk_cnt_q < n_cnt)
    else $error("probe ran past the slot count");

  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD && mod_done |-> N_W'(mod_rem) < n_cnt)
    else $error("home slot out of range");

  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_o == '0)
    else $error("nonzero slot on failed request");
`endif

endmodule

@@ test/tb_linear_probe_hash_table_core.sv @@
localparam int unsigned LPHT_MAX_SLOTS = 64;

class hash_scoreboard;
  typedef struct packed {
    lpht_pkg::status_e              status;
    logic [lpht_pkg::SLOT_W-1:0]    slot;
  } reply_t;

  lpht_pkg::tag_e                slot_tag [LPHT_MAX_SLOTS];
  logic [lpht_pkg::KEY_W-1:0]    slot_key [LPHT_MAX_SLOTS];
  logic [lpht_pkg::CFG_W-1:0]    slot_count;
  reply_t                        expected_replies [$];
  int unsigned                   fail_count;

  function new();
    for (int i = 0; i < LPHT_MAX_SLOTS; i++) begin
      slot_tag[i] = lpht_pkg::TAG_EMPTY;
      slot_key[i] = '0;
    end
    slot_count = lpht_pkg::SLOT_COUNT_RST;
    fail_count = 0;
  endfunction

  function void set_slot_count(logic [lpht_pkg::CFG_W-1:0] value);
    slot_count = value;
  endfunction

  function int unsigned active_slots();
    if (slot_count < 1) return 1;
    if (slot_count > LPHT_MAX_SLOTS) return LPHT_MAX_SLOTS;
    return slot_count;
  endfunction

  function int unsigned outstanding();
    return expected_replies.size();
  endfunction

  function void apply_request(logic [lpht_pkg::OP_W-1:0] op, logic [lpht_pkg::KEY_W-1:0] k);
    int unsigned n;
    int unsigned idx;
    bit done;
    reply_t reply;
    n = active_slots();
    done = 1'b0;
    reply.status = lpht_pkg::ST_NOT_FOUND;
    reply.slot = '0;
    idx = 32'(k) % n;
    if (op == lpht_pkg::OP_INSERT) begin
      reply.status = lpht_pkg::ST_FULL;
      for (int unsigned i = 0; i < n && !done; i++) begin
        if (slot_tag[idx] != lpht_pkg::TAG_USED) begin
          slot_tag[idx] = lpht_pkg::TAG_USED;
          slot_key[idx] = k;
          reply.status = lpht_pkg::ST_OK;
          reply.slot = 6'(idx);
          done = 1'b1;
        end else begin
          idx = (idx + 1 == n) ? 0 : idx + 1;
        end
      end
    end else if (op == lpht_pkg::OP_SEARCH || op == lpht_pkg::OP_DELETE) begin
      for (int unsigned i = 0; i < n && !done; i++) begin
        if (slot_tag[idx] == lpht_pkg::TAG_EMPTY) begin
          done = 1'b1;
        end else if (slot_tag[idx] == lpht_pkg::TAG_USED && slot_key[idx] == k) begin
          if (op == lpht_pkg::OP_DELETE) slot_tag[idx] = lpht_pkg::TAG_DELETED;
          reply.status = lpht_pkg::ST_OK;
          reply.slot = 6'(idx);
          done = 1'b1;
        end else begin
          idx = (idx + 1 == n) ? 0 : idx + 1;
        end
      end
    end
    expected_replies.push_back(reply);
  endfunction

  function void check_reply(logic [lpht_pkg::STAT_W-1:0] got_status,
                            logic [lpht_pkg::SLOT_W-1:0] got_slot);
    reply_t want;
    if (expected_replies.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected reply: status %0d slot %0d", got_status, got_slot);
      return;
    end
    want = expected_replies.pop_front();
    if (got_status !== want.status || got_slot !== want.slot) begin
      fail_count++;
      if (fail_count <= 10)
        $display("reply mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                 want.status, got_status, want.slot, got_slot);
    end
  endfunction
endclass

module tb_linear_probe_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 112;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_BURSTY
  } ready_mode_e;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     req_op    = '0;
  logic [KEY_W-1:0]    req_key   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;

  hash_scoreboard sb = new();
  logic [KEY_W-1:0] known_keys [$];

  linear_probe_hash_table_core #(
    .MAX_SLOTS (LPHT_MAX_SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (req_op),
    .key_i       (req_key),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (rsp_status),
    .slot_o      (rsp_slot)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    @(negedge clk_i);
    in_valid <= 1'b1;
    req_op <= op;
    req_key <= k;
    @(posedge clk_i);
    while (in_ready !== 1'b1) @(posedge clk_i);
    sb.apply_request(op, k);
    if (op == OP_INSERT) begin
      known_keys.push_back(k);
      if (known_keys.size() > 96) void'(known_keys.pop_front());
    end
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] value);
    pause_sender(1);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.set_slot_count(value);
  endtask

  // mix of stored keys, colliding small keys, keys near the top and wide random keys
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = sb.active_slots();
    if (r < 45 && known_keys.size() != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r < 75) return 31'($urandom_range(0, 4 * n));
    if (r < 85) return KEY_MAX - 31'($urandom_range(0, 4 * n));
    return 31'($urandom);
  endfunction

  task automatic run_phase(input int unsigned items, input bit with_gaps);
    int unsigned burst_left;
    int unsigned r;
    logic [OP_W-1:0] op;
    burst_left = 0;
    for (int unsigned i = 0; i < items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if (with_gaps)
          pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                   : $urandom_range(1, 8));
      end
      burst_left--;
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_INSERT;
      else if (r < 70) op = OP_SEARCH;
      else if (r < 95) op = OP_DELETE;
      else op = OP_UNUSED;
      send_request(op, pick_key());
    end
  endtask

  // collisions, wraparound, tombstones, duplicates and the unused op at 64 slots
  task automatic run_directed();
    send_request(OP_INSERT, 31'd0);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, 31'd64);
    send_request(OP_INSERT, 31'd127);
    send_request(OP_SEARCH, 31'd127);
    send_request(OP_SEARCH, 31'd5);
    send_request(OP_DELETE, 31'd64);
    send_request(OP_SEARCH, 31'd127);
    send_request(OP_SEARCH, 31'd64);
    send_request(OP_INSERT, 31'd128);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_UNUSED, 31'd0);
    send_request(OP_UNUSED, KEY_MAX);
    send_request(OP_DELETE, 31'd0);
    send_request(OP_SEARCH, 31'd0);
    send_request(OP_DELETE, 31'd99);
    send_request(OP_SEARCH, KEY_MAX);
    send_request(OP_INSERT, 31'h4000_0000);
    send_request(OP_DELETE, KEY_MAX);
    send_request(OP_SEARCH, KEY_MAX);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) sb.check_reply(rsp_status, rsp_slot);
  end

  initial begin : rx_pattern
    ready_mode_e mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode = RDY_ALWAYS;
    mode_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(1, 60);
          end
        end
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_counts [0:14];
    phase_counts = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd3, 7'd64, 7'd5, 7'd17,
                     7'd64, 7'd8, 7'd33, 7'd1, 7'd127, 7'd11, 7'd64};
    phase_counts[10] = 7'($urandom_range(2, 63));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < 15; p++) begin
      reconfigure(phase_counts[p]);
      run_phase(PHASE_ITEMS, (p % 3) != 1);
    end
    pause_sender(1);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
